### rtl/slc_pkg.sv
// ----------------------------------------------------------------------------
// slc_pkg
// shared types and codes for the sharded lru lookup cache
// ----------------------------------------------------------------------------
`default_nettype none

package slc_pkg;

   typedef enum logic [1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_STATS  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_SHARD = 2'd1,
      ST_EXEC  = 2'd2
   } state_type;

   typedef struct packed {
      logic capture;
      logic read;
      logic commit;
   } ctrl_type;

   localparam logic [3:0] CAP_RESET = 4'd8;
   localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

### rtl/slc_ctrl.sv
// ----------------------------------------------------------------------------
// slc_ctrl
// transaction sequencer: capture, shard select and row read, commit
// ----------------------------------------------------------------------------
`default_nettype none

module slc_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   output slc_pkg::ctrl_type      ctrl
);

   slc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= slc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         slc_pkg::ST_IDLE: begin
            if (start) state_in = slc_pkg::ST_SHARD;
         end
         slc_pkg::ST_SHARD: begin
            state_in = slc_pkg::ST_EXEC;
         end
         slc_pkg::ST_EXEC: begin
            state_in = slc_pkg::ST_IDLE;
         end
         default: begin
            state_in = slc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl = '0;
      busy = 1'b1;
      unique case (state_ff)
         slc_pkg::ST_IDLE: begin
            busy = 1'b0;
            ctrl.capture = start;
         end
         slc_pkg::ST_SHARD: begin
            ctrl.read = 1'b1;
         end
         slc_pkg::ST_EXEC: begin
            ctrl.commit = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/slc_datapath.sv
// ----------------------------------------------------------------------------
// slc_datapath
// shard rows, lane compare, recency update, counters and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module slc_datapath #(
   parameter int SHARD_COUNT   = 16,
   parameter int SHARD_ENTRIES = 8,
   parameter int HANDLE_WIDTH  = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire slc_pkg::ctrl_type  ctrl,
   input  wire logic [3:0]         capacity,
   input  wire logic [1:0]         req_command,
   input  wire logic [63:0]        req_key_hash,
   input  wire logic [63:0]        req_check_tag,
   input  wire logic [31:0]        req_value_handle,
   output logic                    rsp_valid,
   output logic                    rsp_hit,
   output logic [31:0]             rsp_found_handle,
   output logic                    rsp_evicted,
   output logic [31:0]             rsp_hit_count,
   output logic [31:0]             rsp_miss_count,
   output logic [31:0]             rsp_evict_count,
   output logic [7:0]              rsp_entry_count
);

   localparam int EPS   = SHARD_ENTRIES;
   localparam int SHW   = (SHARD_COUNT > 1) ? $clog2(SHARD_COUNT) : 1;
   localparam int RW    = (EPS > 1) ? $clog2(EPS) : 1;
   localparam int FW    = $clog2(EPS + 1);
   localparam int TW    = $clog2(SHARD_COUNT * EPS + 1);
   localparam int HW    = HANDLE_WIDTH;
   localparam int SW    = 17;
   localparam int RSH   = 24;
   localparam logic [24:0] RECIP = 25'((1 << RSH) / SHARD_COUNT);

   // weight of each key byte modulo the shard count
   function automatic logic [7:0][5:0] fold_weights();
      logic [7:0][5:0] w;
      int unsigned p;
      w = '0;
      p = 1 % SHARD_COUNT;
      for (int i = 0; i < 8; i++) begin
         w[i] = 6'(p);
         for (int k = 0; k < 8; k++) p = (p * 2) % SHARD_COUNT;
      end
      return w;
   endfunction

   localparam logic [7:0][5:0] WEIGHT = fold_weights();

   // request registers
   logic [1:0]          cmd_ff;
   logic [63:0]         key_ff;
   logic [63:0]         tag_ff;
   logic [HW-1:0]       handle_ff;
   logic [SW-1:0]       fold_ff;
   logic [SHW-1:0]      shard_ff;

   // shard rows
   logic [EPS-1:0][63:0]    key_mem    [SHARD_COUNT];
   logic [EPS-1:0][63:0]    tag_mem    [SHARD_COUNT];
   logic [EPS-1:0][HW-1:0]  handle_mem [SHARD_COUNT];
   logic [EPS-1:0][RW-1:0]  rank_mem   [SHARD_COUNT];
   logic [EPS-1:0][63:0]    rd_key_ff;
   logic [EPS-1:0][63:0]    rd_tag_ff;
   logic [EPS-1:0][HW-1:0]  rd_handle_ff;
   logic [EPS-1:0][RW-1:0]  rd_rank_ff;
   logic [EPS-1:0]          valid_ff [SHARD_COUNT];

   logic [31:0]  hits_ff, misses_ff, evicts_ff;
   logic [TW-1:0] total_ff;

   // fold of the key into a small residue sum
   logic [SW-1:0] fold_in;
   logic [63:0]   hext;
   always_comb begin
      fold_in = '0;
      for (int i = 0; i < 8; i++) begin
         fold_in = fold_in + SW'(req_key_hash[8*i +: 8] * WEIGHT[i]);
      end
      hext = {32'h0, req_value_handle};
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff    <= req_command;
         key_ff    <= req_key_hash;
         tag_ff    <= req_check_tag;
         handle_ff <= hext[HW-1:0];
         fold_ff   <= fold_in;
      end
   end

   // residue of the folded sum
   logic [41:0]   prod;
   logic [SW-1:0] quo, rem0, rem1;
   logic [SHW-1:0] shard;
   always_comb begin
      prod  = 42'(fold_ff) * 42'(RECIP);
      quo   = SW'(prod >> RSH);
      rem0  = fold_ff - SW'(quo * SW'(SHARD_COUNT));
      rem1  = (rem0 >= SW'(SHARD_COUNT)) ? rem0 - SW'(SHARD_COUNT) : rem0;
      shard = rem1[SHW-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.read) begin
         shard_ff     <= shard;
         rd_key_ff    <= key_mem[shard];
         rd_tag_ff    <= tag_mem[shard];
         rd_handle_ff <= handle_mem[shard];
         rd_rank_ff   <= rank_mem[shard];
      end
   end

   // row update
   logic [EPS-1:0]          row_valid, mvec, mone, victim, v2, free1;
   logic [EPS-1:0]          valid_in;
   logic [EPS-1:0][63:0]    tag_in;
   logic [EPS-1:0][HW-1:0]  handle_in;
   logic [EPS-1:0][RW-1:0]  rank_in;
   logic [EPS-1:0][63:0]    key_in;
   logic                    seen, fseen, tag_ok, evict, we, clr;
   logic [RW-1:0]           hrank;
   logic [63:0]             htag;
   logic [HW-1:0]           hhandle;
   logic [FW-1:0]           fill;
   logic [6:0]              cap7, fill7, last7;
   logic                    hit_in, evicted_in;
   logic [31:0]             hits_in, misses_in, evicts_in;
   logic [TW-1:0]           total_in;
   logic [63:0]             hout;

   always_comb begin
      row_valid = valid_ff[shard_ff];
      mone  = '0;
      seen  = 1'b0;
      hrank = '0;
      htag  = '0;
      hhandle = '0;
      fill  = '0;
      for (int i = 0; i < EPS; i++) begin
         mvec[i] = row_valid[i] && (rd_key_ff[i] == key_ff);
         if (mvec[i] && !seen) begin
            mone[i] = 1'b1;
            seen = 1'b1;
         end
         fill = fill + FW'(row_valid[i]);
      end
      for (int i = 0; i < EPS; i++) begin
         if (mone[i]) begin
            hrank   = hrank | rd_rank_ff[i];
            htag    = htag | rd_tag_ff[i];
            hhandle = hhandle | rd_handle_ff[i];
         end
      end
      tag_ok = seen && (htag == tag_ff);

      cap7 = {3'b0, capacity};
      if (cap7 == 7'd0) cap7 = 7'd1;
      if (cap7 > 7'(EPS)) cap7 = 7'(EPS);
      fill7 = 7'(fill);
      last7 = fill7 - 7'd1;
      evict = (fill7 >= cap7) && (fill7 != 7'd0);

      victim = '0;
      free1  = '0;
      fseen  = 1'b0;
      for (int i = 0; i < EPS; i++) begin
         victim[i] = evict && row_valid[i] && (7'(rd_rank_ff[i]) == last7);
      end
      v2 = row_valid & ~victim;
      for (int i = 0; i < EPS; i++) begin
         if (!v2[i] && !fseen) begin
            free1[i] = 1'b1;
            fseen = 1'b1;
         end
      end

      key_in     = rd_key_ff;
      tag_in     = rd_tag_ff;
      handle_in  = rd_handle_ff;
      rank_in    = rd_rank_ff;
      valid_in   = row_valid;
      we         = 1'b0;
      clr        = 1'b0;
      hit_in     = 1'b0;
      evicted_in = 1'b0;
      hits_in    = hits_ff;
      misses_in  = misses_ff;
      evicts_in  = evicts_ff;
      total_in   = total_ff;
      hout       = '0;

      case (slc_pkg::cmd_type'(cmd_ff))
         slc_pkg::CMD_LOOKUP: begin
            if (tag_ok) begin
               hit_in = 1'b1;
               hout[HW-1:0] = hhandle;
               we = 1'b1;
               for (int i = 0; i < EPS; i++) begin
                  if (mone[i]) rank_in[i] = '0;
                  else if (row_valid[i] && rd_rank_ff[i] < hrank)
                     rank_in[i] = rd_rank_ff[i] + RW'(1);
               end
               if (hits_ff != slc_pkg::CNT_MAX) hits_in = hits_ff + 32'd1;
            end else begin
               if (misses_ff != slc_pkg::CNT_MAX) misses_in = misses_ff + 32'd1;
            end
         end
         slc_pkg::CMD_INSERT: begin
            we = 1'b1;
            if (seen) begin
               for (int i = 0; i < EPS; i++) begin
                  if (mone[i]) begin
                     tag_in[i]    = tag_ff;
                     handle_in[i] = handle_ff;
                     rank_in[i]   = '0;
                  end else if (row_valid[i] && rd_rank_ff[i] < hrank) begin
                     rank_in[i] = rd_rank_ff[i] + RW'(1);
                  end
               end
            end else begin
               for (int i = 0; i < EPS; i++) begin
                  if (free1[i]) begin
                     key_in[i]    = key_ff;
                     tag_in[i]    = tag_ff;
                     handle_in[i] = handle_ff;
                     rank_in[i]   = '0;
                  end else if (v2[i]) begin
                     rank_in[i] = rd_rank_ff[i] + RW'(1);
                  end
               end
               valid_in = v2 | free1;
               if (evict) begin
                  evicted_in = 1'b1;
                  if (evicts_ff != slc_pkg::CNT_MAX) evicts_in = evicts_ff + 32'd1;
               end else begin
                  total_in = total_ff + TW'(1);
               end
            end
         end
         slc_pkg::CMD_CLEAR: begin
            clr       = 1'b1;
            hits_in   = '0;
            misses_in = '0;
            total_in  = '0;
         end
         slc_pkg::CMD_STATS: begin
            we = 1'b0;
         end
         default: begin
            we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit && we) begin
         key_mem[shard_ff]    <= key_in;
         tag_mem[shard_ff]    <= tag_in;
         handle_mem[shard_ff] <= handle_in;
         rank_mem[shard_ff]   <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SHARD_COUNT; s++) valid_ff[s] <= '0;
         hits_ff   <= '0;
         misses_ff <= '0;
         evicts_ff <= '0;
         total_ff  <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= ctrl.commit;
         if (ctrl.commit) begin
            if (clr) begin
               for (int s = 0; s < SHARD_COUNT; s++) valid_ff[s] <= '0;
            end else if (we) begin
               valid_ff[shard_ff] <= valid_in;
            end
            hits_ff   <= hits_in;
            misses_ff <= misses_in;
            evicts_ff <= evicts_in;
            total_ff  <= total_in;
         end
      end
   end

   logic [15:0] total16;
   always_comb begin
      total16 = 16'(total_in);
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         rsp_hit          <= hit_in;
         rsp_found_handle <= hout[31:0];
         rsp_evicted      <= evicted_in;
         rsp_hit_count    <= hits_in;
         rsp_miss_count   <= misses_in;
         rsp_evict_count  <= evicts_in;
         rsp_entry_count  <= (total16 > 16'd255) ? 8'hFF : total16[7:0];
      end
   end

endmodule

`default_nettype wire

### rtl/sharded_lru_lookup_cache_unit.sv
// ----------------------------------------------------------------------------
// sharded_lru_lookup_cache_unit
// sharded lru cache of 64-bit keys with tag check and statistics
//
//   channel   handshake             payload
//   request   start / busy          req_command, req_key_hash, req_check_tag,
//                                   req_value_handle
//   response  rsp_valid strobe      rsp_hit .. rsp_entry_count
//   csr       psel / penable        shard_capacity at byte address 0
//
// a transaction runs as key fold at accept, shard residue and row read, then
// row update; the result strobe follows in the cycle after the update while
// the next transaction can already be accepted. the key residue stage and the
// single row read-modify-write set the length of a transaction. reset clears
// valid bits and counters at once, no sweep. the receiver cannot stall; each
// result is shown for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sharded_lru_lookup_cache_unit #(
   parameter int SHARD_COUNT   = 16,
   parameter int SHARD_ENTRIES = 8,
   parameter int HANDLE_WIDTH  = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_command,
   input  wire logic [63:0] req_key_hash,
   input  wire logic [63:0] req_check_tag,
   input  wire logic [31:0] req_value_handle,
   output logic             rsp_valid,
   output logic             rsp_hit,
   output logic [31:0]      rsp_found_handle,
   output logic             rsp_evicted,
   output logic [31:0]      rsp_hit_count,
   output logic [31:0]      rsp_miss_count,
   output logic [31:0]      rsp_evict_count,
   output logic [7:0]       rsp_entry_count,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   slc_pkg::ctrl_type ctrl;
   logic [3:0] cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= slc_pkg::CAP_RESET;
      end else if (psel && penable && pwrite && !paddr[2]) begin
         cap_ff <= pwdata[3:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = paddr[2] ? 32'h0 : {28'h0, cap_ff};

   slc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .ctrl  (ctrl)
   );

   slc_datapath #(
      .SHARD_COUNT   (SHARD_COUNT),
      .SHARD_ENTRIES (SHARD_ENTRIES),
      .HANDLE_WIDTH  (HANDLE_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .capacity         (cap_ff),
      .req_command      (req_command),
      .req_key_hash     (req_key_hash),
      .req_check_tag    (req_check_tag),
      .req_value_handle (req_value_handle),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_found_handle (rsp_found_handle),
      .rsp_evicted      (rsp_evicted),
      .rsp_hit_count    (rsp_hit_count),
      .rsp_miss_count   (rsp_miss_count),
      .rsp_evict_count  (rsp_evict_count),
      .rsp_entry_count  (rsp_entry_count)
   );

endmodule

`default_nettype wire

### dv/slc_checker.sv
// ----------------------------------------------------------------------------
// slc_checker
// watches the request and response channels of the sharded lru lookup cache,
// predicts each response from its own copy of the shard tables and counters,
// and compares it field by field with what the block returns
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slc_checker #(
   parameter int SHARD_COUNT   = 16,
   parameter int SHARD_ENTRIES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [1:0]  req_command,
   input  wire logic [63:0] req_key_hash,
   input  wire logic [63:0] req_check_tag,
   input  wire logic [31:0] req_value_handle,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_hit,
   input  wire logic [31:0] rsp_found_handle,
   input  wire logic        rsp_evicted,
   input  wire logic [31:0] rsp_hit_count,
   input  wire logic [31:0] rsp_miss_count,
   input  wire logic [31:0] rsp_evict_count,
   input  wire logic [7:0]  rsp_entry_count,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output int               fail_count,
   output int               pending_count,
   output int               lookup_hits_seen,
   output int               evictions_seen
);

   localparam int SLOTS = SHARD_COUNT * SHARD_ENTRIES;

   typedef struct packed {
      logic        hit;
      logic [31:0] found_handle;
      logic        evicted;
      logic [31:0] hit_count;
      logic [31:0] miss_count;
      logic [31:0] evict_count;
      logic [7:0]  entry_count;
   } cache_reply_type;

   logic [63:0] slot_key [SLOTS];
   logic [63:0] slot_tag [SLOTS];
   logic [31:0] slot_handle [SLOTS];
   logic        slot_valid [SLOTS];
   int          slot_rank [SLOTS];
   int          fill [SHARD_COUNT];
   logic [31:0] hits_n, misses_n, evicts_n;
   logic [3:0]  capacity_reg;
   cache_reply_type expected_replies [$];

   function automatic logic [31:0] bump(logic [31:0] v);
      return (v == slc_pkg::CNT_MAX) ? v : v + 32'd1;
   endfunction

   function automatic void promote(int base, int s);
      int r;
      r = slot_rank[s];
      for (int i = 0; i < SHARD_ENTRIES; i++)
         if (slot_valid[base+i] && slot_rank[base+i] < r) slot_rank[base+i]++;
      slot_rank[s] = 0;
   endfunction

   function automatic cache_reply_type predict_reply(slc_pkg::cmd_type cmd,
                                                     logic [63:0] key,
                                                     logic [63:0] tag,
                                                     logic [31:0] hnd);
      cache_reply_type r;
      int shard, base, match, cap, last, free_slot, total;
      r = '0;
      shard = int'(key % SHARD_COUNT);
      base = shard * SHARD_ENTRIES;
      match = -1;
      for (int i = 0; i < SHARD_ENTRIES; i++)
         if (match < 0 && slot_valid[base+i] && slot_key[base+i] == key) match = base + i;
      cap = (capacity_reg < 1) ? 1 :
            (capacity_reg > SHARD_ENTRIES) ? SHARD_ENTRIES : int'(capacity_reg);
      case (cmd)
         slc_pkg::CMD_LOOKUP: begin
            if (match >= 0 && slot_tag[match] == tag) begin
               r.hit = 1'b1;
               r.found_handle = slot_handle[match];
               promote(base, match);
               hits_n = bump(hits_n);
            end else begin
               misses_n = bump(misses_n);
            end
         end
         slc_pkg::CMD_INSERT: begin
            if (match >= 0) begin
               slot_tag[match] = tag;
               slot_handle[match] = hnd;
               promote(base, match);
            end else begin
               if (fill[shard] >= cap && fill[shard] > 0) begin
                  last = fill[shard] - 1;
                  for (int i = 0; i < SHARD_ENTRIES; i++)
                     if (slot_valid[base+i] && slot_rank[base+i] == last) begin
                        slot_valid[base+i] = 1'b0;
                        slot_rank[base+i] = 0;
                        break;
                     end
                  fill[shard]--;
                  r.evicted = 1'b1;
                  evicts_n = bump(evicts_n);
               end
               free_slot = base;
               for (int i = SHARD_ENTRIES - 1; i >= 0; i--)
                  if (!slot_valid[base+i]) free_slot = base + i;
               for (int i = 0; i < SHARD_ENTRIES; i++)
                  if (slot_valid[base+i]) slot_rank[base+i]++;
               slot_valid[free_slot] = 1'b1;
               slot_key[free_slot] = key;
               slot_tag[free_slot] = tag;
               slot_handle[free_slot] = hnd;
               slot_rank[free_slot] = 0;
               fill[shard]++;
            end
         end
         slc_pkg::CMD_CLEAR: begin
            for (int i = 0; i < SLOTS; i++) begin
               slot_valid[i] = 1'b0;
               slot_rank[i] = 0;
            end
            for (int i = 0; i < SHARD_COUNT; i++) fill[i] = 0;
            hits_n = '0;
            misses_n = '0;
         end
         default: ;
      endcase
      total = 0;
      for (int i = 0; i < SHARD_COUNT; i++) total += fill[i];
      r.hit_count = hits_n;
      r.miss_count = misses_n;
      r.evict_count = evicts_n;
      r.entry_count = (total > 255) ? 8'd255 : 8'(total);
      return r;
   endfunction

   function automatic void report(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= 10)
            $display("mismatch %s: expected %h, got %h", name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      cache_reply_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_valid[i] = 1'b0;
            slot_rank[i] = 0;
         end
         for (int i = 0; i < SHARD_COUNT; i++) fill[i] = 0;
         hits_n = '0;
         misses_n = '0;
         evicts_n = '0;
         capacity_reg = slc_pkg::CAP_RESET;
         expected_replies.delete();
      end else begin
         if (psel && penable && pwrite && paddr == 3'd0) capacity_reg = pwdata[3:0];
         if (rsp_valid) begin
            if (expected_replies.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected response transaction");
            end else begin
               want = expected_replies.pop_front();
               report("hit", 32'(want.hit), 32'(rsp_hit));
               report("found_handle", want.found_handle, rsp_found_handle);
               report("evicted", 32'(want.evicted), 32'(rsp_evicted));
               report("hit_count", want.hit_count, rsp_hit_count);
               report("miss_count", want.miss_count, rsp_miss_count);
               report("evict_count", want.evict_count, rsp_evict_count);
               report("entry_count", 32'(want.entry_count), 32'(rsp_entry_count));
               if (want.hit) lookup_hits_seen++;
               if (want.evicted) evictions_seen++;
            end
         end
         if (start && !busy)
            expected_replies.insert(expected_replies.size(),
                                    predict_reply(slc_pkg::cmd_type'(req_command),
                                                  req_key_hash, req_check_tag,
                                                  req_value_handle));
      end
      pending_count = expected_replies.size();
   end

   initial begin
      fail_count = 0;
      pending_count = 0;
      lookup_hits_seen = 0;
      evictions_seen = 0;
   end

endmodule

### dv/tb_sharded_lru_lookup_cache_unit.sv
// ----------------------------------------------------------------------------
// tb_sharded_lru_lookup_cache_unit
// drives directed and random lookup, insert, clear and stats commands through
// several shard capacities with random sender gaps; a separate checker
// predicts and compares every response
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sharded_lru_lookup_cache_unit;

   logic        clock, reset, start, busy;
   logic [1:0]  req_command;
   logic [63:0] req_key_hash, req_check_tag;
   logic [31:0] req_value_handle;
   logic        rsp_valid, rsp_hit, rsp_evicted;
   logic [31:0] rsp_found_handle, rsp_hit_count, rsp_miss_count, rsp_evict_count;
   logic [7:0]  rsp_entry_count;
   logic        psel, penable, pwrite, pready;
   logic [2:0]  paddr;
   logic [31:0] pwdata, prdata;
   int          fail_count, pending_count, hits_seen, evicts_seen;
   int          gap_pct, sent;
   logic [63:0] key_pool [16];
   logic [63:0] tag_pool [16];

   sharded_lru_lookup_cache_unit dut (.*);

   slc_checker checker_i (.*, .lookup_hits_seen(hits_seen), .evictions_seen(evicts_seen));

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

   // start stays high after an accept until the next gap or drain
   task automatic send_cmd(slc_pkg::cmd_type cmd, logic [63:0] key, logic [63:0] tag,
                           logic [31:0] hnd);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_key_hash <= key;
      req_check_tag <= tag;
      req_value_handle <= hnd;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_capacity(logic [31:0] v);
      drain();
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= 3'd0;
      pwdata <= v;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic random_cmd();
      int k;
      int p;
      logic [63:0] tag;
      k = $urandom_range(15);
      p = $urandom_range(99);
      tag = ($urandom_range(9) == 0) ? {$urandom, $urandom} : tag_pool[k];
      if (p < 45) send_cmd(slc_pkg::CMD_LOOKUP, key_pool[k], tag, $urandom);
      else if (p < 88) send_cmd(slc_pkg::CMD_INSERT, key_pool[k], tag_pool[k], $urandom);
      else if (p < 90) send_cmd(slc_pkg::CMD_CLEAR, {$urandom, $urandom},
                                {$urandom, $urandom}, $urandom);
      else if (p < 96) send_cmd(slc_pkg::CMD_STATS, {$urandom, $urandom},
                                {$urandom, $urandom}, $urandom);
      else send_cmd(slc_pkg::cmd_type'($urandom_range(1)), {$urandom, $urandom},
                    {$urandom, $urandom}, $urandom);
   endtask

   initial begin
      logic [3:0] caps [6];
      caps = '{4'd0, 4'd1, 4'd3, 4'd15, 4'd8, 4'd2};
      reset = 1'b1;
      start = 1'b0;
      req_command = slc_pkg::CMD_LOOKUP;
      req_key_hash = '0;
      req_check_tag = '0;
      req_value_handle = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      gap_pct = 0;
      sent = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes, tag mismatch, overwrite, eviction at low capacity
      send_cmd(slc_pkg::CMD_LOOKUP, '0, '0, '0);
      send_cmd(slc_pkg::CMD_INSERT, '0, '0, '0);
      send_cmd(slc_pkg::CMD_LOOKUP, '0, '0, '1);
      send_cmd(slc_pkg::CMD_INSERT, '1, '1, '1);
      send_cmd(slc_pkg::CMD_LOOKUP, '1, '1, '0);
      send_cmd(slc_pkg::CMD_LOOKUP, '1, 64'h5555_5555_5555_5555, '0);
      send_cmd(slc_pkg::CMD_INSERT, '1, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_5555);
      send_cmd(slc_pkg::CMD_LOOKUP, '1, 64'hAAAA_AAAA_AAAA_AAAA, '0);
      for (int i = 0; i < 10; i++)
         send_cmd(slc_pkg::CMD_INSERT, {60'(i), 4'h3}, 64'(i), 32'(i));
      send_cmd(slc_pkg::CMD_STATS, '1, '1, '1);
      write_capacity(32'd1);
      send_cmd(slc_pkg::CMD_INSERT, 64'h77, 64'h1, 32'h1);
      send_cmd(slc_pkg::CMD_INSERT, 64'h87, 64'h2, 32'h2);
      send_cmd(slc_pkg::CMD_LOOKUP, 64'h77, 64'h1, '0);
      write_capacity(32'hFFFF_FFF0);
      send_cmd(slc_pkg::CMD_INSERT, 64'h3, 64'h9, 32'h9);
      send_cmd(slc_pkg::CMD_CLEAR, '0, '0, '0);
      send_cmd(slc_pkg::CMD_STATS, '0, '0, '0);

      for (int ph = 0; ph < 6; ph++) begin
         write_capacity({28'(ph) << 4, caps[ph]});
         for (int k = 0; k < 16; k++) begin
            key_pool[k] = {$urandom, $urandom};
            if ($urandom_range(1)) key_pool[k][3:0] = 4'(ph);
            tag_pool[k] = {$urandom, $urandom};
         end
         gap_pct = (ph < 2) ? 28 : (ph < 4) ? 86 : 0;
         for (int n = 0; n < 100; n++) random_cmd();
      end

      drain();
      $display("ran %0d commands over six capacity settings", sent);
      $display("%0d lookup hits and %0d evictions predicted", hits_seen, evicts_seen);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### files.f
rtl/slc_pkg.sv
rtl/slc_ctrl.sv
rtl/slc_datapath.sv
rtl/sharded_lru_lookup_cache_unit.sv
dv/slc_checker.sv
dv/tb_sharded_lru_lookup_cache_unit.sv
